[design/ordered_dither_to_monochrome_top_assert.svh]
// assertion macros for the ordered dither block checker
// used by ordfd_checker.sv only; no other dependencies
`ifndef ORDERED_DITHER_TO_MONOCHROME_TOP_ASSERT_SVH
`define ORDERED_DITHER_TO_MONOCHROME_TOP_ASSERT_SVH

// property checked every clock edge, suspended while reset is high
`define ORDFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked every clock edge, reset included
`define ORDFD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/ordfd_pkg.sv]
// shared types, codes and defaults for the ordered dither block
// no dependencies
package ordfd_pkg;

   // default palette depth and queue depth
   localparam int DEFAULT_PALETTE_ENTRIES = 256;
   localparam int DEFAULT_QUEUE_DEPTH     = 2;

   // command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   // pixel format codes
   localparam logic [1:0] FMT_PALETTE = 2'd0;
   localparam logic [1:0] FMT_RGB16   = 2'd1;
   localparam logic [1:0] FMT_RGB24   = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_PIXEL_FORMAT = 2'd0;
   localparam logic [1:0] CSR_WHITE_INDEX  = 2'd1;
   localparam logic [1:0] CSR_BLACK_INDEX  = 2'd2;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [1:0] pixel_format;
      logic [7:0] white_index;
      logic [7:0] black_index;
   } cfg_type;

   // one classified pixel on its way from front to back
   typedef struct packed {
      logic       from_palette;
      logic [7:0] pal_level;
      logic [6:0] level_sum;
      logic [7:0] threshold;
      logic       line_end;
   } work_type;

endpackage

[design/ordfd_if.sv]
// request and response channel interfaces for the ordered dither block
// no dependencies
interface ordfd_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [23:0] pixel_value;
   logic [7:0]  entry_index;
   logic [9:0]  red_level;
   logic [9:0]  green_level;
   logic [9:0]  blue_level;
   logic        line_end;
   logic        image_start;

   modport source (
      output valid, command, pixel_value, entry_index, red_level, green_level,
             blue_level, line_end, image_start,
      input  ready
   );
   modport sink (
      input  valid, command, pixel_value, entry_index, red_level, green_level,
             blue_level, line_end, image_start,
      output ready
   );
endinterface

interface ordfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_index;
   logic       is_white;
   logic       end_of_line;

   modport source (
      output valid, out_index, is_white, end_of_line,
      input  ready
   );
   modport sink (
      input  valid, out_index, is_white, end_of_line,
      output ready
   );
endinterface

[design/ordered_dither_to_monochrome_top.sv]
// top level of the ordered dither to monochrome block
// depends on ordfd_pkg, ordfd_if, ordfd_csr, ordfd_front, ordfd_queue, ordfd_back
//
//   port       | dir | kind               | beat carries
//   req_bus    | in  | valid/ready        | load command or one pixel with line marks
//   rsp_bus    | out | valid/ready        | colour index, white flag, end of line
//   csr_*      | in  | write enable/index | pixel_format, white_index, black_index
//
// one beat per clock while rsp_bus is ready; a taken pixel reaches rsp_bus through
// the front stage, the queue and the output register; a load gives no response beat.
// reset is synchronous and clears phases, queue and valid flags; palette entries
// hold nothing defined until loaded and get no clearing pass.
// a stalled rsp_bus fills the output register, then the two queue entries, then the
// front stage, after which req_bus.ready drops.
module ordered_dither_to_monochrome_top #(
   parameter int PALETTE_ENTRIES = ordfd_pkg::DEFAULT_PALETTE_ENTRIES,
   parameter int QUEUE_DEPTH     = ordfd_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   ordfd_req_if.sink  req_bus,
   ordfd_rsp_if.source rsp_bus,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wr_data
);

   ordfd_pkg::cfg_type  cfg;
   ordfd_pkg::work_type fq_data, qb_data;
   logic                fq_valid, fq_ready;
   logic                qb_valid, qb_ready;

   ordfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   ordfd_front #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .cfg        (cfg),
      .work_valid (fq_valid),
      .work       (fq_data),
      .work_ready (fq_ready)
   );

   ordfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_data  (fq_data),
      .push_ready (fq_ready),
      .pop_valid  (qb_valid),
      .pop_data   (qb_data),
      .pop_ready  (qb_ready)
   );

   ordfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (qb_valid),
      .work       (qb_data),
      .work_ready (qb_ready),
      .cfg        (cfg),
      .rsp        (rsp_bus)
   );

endmodule

[design/ordfd_csr.sv]
// configuration registers of the ordered dither block
// depends on ordfd_pkg
module ordfd_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wr_data,
   output ordfd_pkg::cfg_type  cfg
);

   logic [1:0] pixel_format_ff, pixel_format_in;
   logic [7:0] white_index_ff, white_index_in;
   logic [7:0] black_index_ff, black_index_in;

   // write decode, unknown indexes are dropped
   always_comb begin
      pixel_format_in = pixel_format_ff;
      white_index_in  = white_index_ff;
      black_index_in  = black_index_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ordfd_pkg::CSR_PIXEL_FORMAT: pixel_format_in = csr_wr_data[1:0];
            ordfd_pkg::CSR_WHITE_INDEX:  white_index_in  = csr_wr_data;
            ordfd_pkg::CSR_BLACK_INDEX:  black_index_in  = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= ordfd_pkg::FMT_PALETTE;
         white_index_ff  <= 8'd0;
         black_index_ff  <= 8'd255;
      end else begin
         pixel_format_ff <= pixel_format_in;
         white_index_ff  <= white_index_in;
         black_index_ff  <= black_index_in;
      end
   end

   assign cfg.pixel_format = pixel_format_ff;
   assign cfg.white_index  = white_index_ff;
   assign cfg.black_index  = black_index_ff;

endmodule

[design/ordfd_front.sv]
// front end: accepts beats, loads the palette, tracks phases, classifies pixels
// depends on ordfd_pkg and ordfd_req_if
module ordfd_front #(
   parameter int PALETTE_ENTRIES = ordfd_pkg::DEFAULT_PALETTE_ENTRIES
) (
   input  logic                clock,
   input  logic                reset,
   ordfd_req_if.sink           req,
   input  ordfd_pkg::cfg_type  cfg,
   output logic                work_valid,
   output ordfd_pkg::work_type work,
   input  logic                work_ready
);

   localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
   localparam logic [9:0]  CLIP_LEVEL = 10'd1000;
   // floor(sum * 256 / 3000) == (sum * LOAD_RECIP) >> 25 for sum <= 3000
   localparam logic [21:0] LOAD_RECIP = 22'd2863328;

   logic [7:0] pal_mem_ff [PALETTE_ENTRIES];

   logic [3:0] col_ff, col_in;
   logic [3:0] row_ff, row_in;
   logic       st_valid_ff, st_valid_in;
   logic       st_from_pal_ff;
   logic       st_pal_ok_ff;
   logic [6:0] st_sum_ff;
   logic [7:0] st_thr_ff;
   logic       st_eol_ff;
   logic [7:0] pal_rd_ff;

   logic        accept, accept_pixel, accept_load;
   logic [3:0]  col_use, row_use;
   logic [9:0]  red_clip, green_clip, blue_clip;
   logic [11:0] load_sum;
   logic [33:0] load_prod;
   logic [7:0]  load_level;
   logic        load_in_range, pix_in_range;
   logic [6:0]  sum16, sum24, pix_sum;
   logic [9:0]  rgb_total;
   logic [7:0]  threshold;

   // 4x4 seed of the recursive threshold matrix
   function automatic logic [5:0] bayer4(input logic [1:0] r, input logic [1:0] c);
      logic [5:0] v;
      case ({r, c})
         4'h0: v = 6'd0;   4'h1: v = 6'd32;  4'h2: v = 6'd8;   4'h3: v = 6'd40;
         4'h4: v = 6'd48;  4'h5: v = 6'd16;  4'h6: v = 6'd56;  4'h7: v = 6'd24;
         4'h8: v = 6'd12;  4'h9: v = 6'd44;  4'hA: v = 6'd4;   4'hB: v = 6'd36;
         4'hC: v = 6'd60;  4'hD: v = 6'd28;  4'hE: v = 6'd52;  4'hF: v = 6'd20;
         default: v = 6'd0;
      endcase
      return v;
   endfunction

   // 16x16 threshold from row and column phase
   function automatic logic [7:0] bayer16(input logic [3:0] r, input logic [3:0] c);
      logic [5:0] d;
      logic [1:0] lo;
      d = bayer4(r[1:0], c[1:0]);
      if (r[2] && c[2])  d = d + 6'd1;
      else if (c[2])     d = d + 6'd2;
      else if (r[2])     d = d + 6'd3;
      if (r[3] && c[3])  lo = 2'd1;
      else if (r[3])     lo = 2'd2;
      else if (c[3])     lo = 2'd3;
      else               lo = 2'd0;
      return {d, lo};
   endfunction

   assign req.ready    = !st_valid_ff || work_ready;
   assign accept       = req.valid && req.ready;
   assign accept_pixel = accept && (req.command == ordfd_pkg::CMD_PIXEL);
   assign accept_load  = accept && (req.command == ordfd_pkg::CMD_LOAD);

   // palette load level, clipped and scaled
   assign red_clip   = (req.red_level   > CLIP_LEVEL) ? CLIP_LEVEL : req.red_level;
   assign green_clip = (req.green_level > CLIP_LEVEL) ? CLIP_LEVEL : req.green_level;
   assign blue_clip  = (req.blue_level  > CLIP_LEVEL) ? CLIP_LEVEL : req.blue_level;
   assign load_sum   = 12'(red_clip) + 12'(green_clip) + 12'(blue_clip);
   assign load_prod  = 34'(load_sum) * 34'(LOAD_RECIP);
   assign load_level = (load_prod[33:25] > 9'd255) ? 8'd255 : load_prod[32:25];

   assign load_in_range = {1'b0, req.entry_index} < 9'(PALETTE_ENTRIES);
   assign pix_in_range  = {1'b0, req.pixel_value[7:0]} < 9'(PALETTE_ENTRIES);

   // channel sums for the direct colour formats
   assign sum16 = 7'(req.pixel_value[4:0]) + 7'(req.pixel_value[10:6])
                + 7'(req.pixel_value[15:11]);
   assign rgb_total = 10'(req.pixel_value[23:16]) + 10'(req.pixel_value[15:8])
                    + 10'(req.pixel_value[7:0]);
   assign sum24   = rgb_total[9:3];
   assign pix_sum = (cfg.pixel_format == ordfd_pkg::FMT_RGB16) ? sum16 : sum24;

   // phase counters, image start clears before use
   assign col_use   = req.image_start ? 4'd0 : col_ff;
   assign row_use   = req.image_start ? 4'd0 : row_ff;
   assign threshold = bayer16(row_use, col_use);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept_pixel) begin
         if (req.line_end) begin
            col_in = 4'd0;
            row_in = row_use + 4'd1;
         end else begin
            col_in = col_use + 4'd1;
            row_in = row_use;
         end
      end
   end

   // stage occupancy
   always_comb begin
      if (accept_pixel)    st_valid_in = 1'b1;
      else if (work_ready) st_valid_in = 1'b0;
      else                 st_valid_in = st_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= 4'd0;
         row_ff      <= 4'd0;
         st_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         st_valid_ff <= st_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (accept_pixel) begin
         st_from_pal_ff <= (cfg.pixel_format == ordfd_pkg::FMT_PALETTE);
         st_pal_ok_ff   <= pix_in_range;
         st_sum_ff      <= pix_sum;
         st_thr_ff      <= threshold;
         st_eol_ff      <= req.line_end;
      end
   end

   // palette memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (accept_load && load_in_range) begin
         pal_mem_ff[req.entry_index[PAL_AW-1:0]] <= load_level;
      end
      if (accept_pixel) begin
         pal_rd_ff <= pal_mem_ff[req.pixel_value[PAL_AW-1:0]];
      end
   end

   assign work_valid        = st_valid_ff;
   assign work.from_palette = st_from_pal_ff;
   assign work.pal_level    = st_pal_ok_ff ? pal_rd_ff : 8'd0;
   assign work.level_sum    = st_sum_ff;
   assign work.threshold    = st_thr_ff;
   assign work.line_end     = st_eol_ff;

endmodule

[design/ordfd_queue.sv]
// short queue between the front end and the back end
// depends on ordfd_pkg
module ordfd_queue #(
   parameter int DEPTH = ordfd_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  ordfd_pkg::work_type push_data,
   output logic                push_ready,
   output logic                pop_valid,
   output ordfd_pkg::work_type pop_data,
   input  logic                pop_ready
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   ordfd_pkg::work_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/ordfd_back.sv]
// back end: scales intensity, compares with threshold, holds the response beat
// depends on ordfd_pkg and ordfd_rsp_if
module ordfd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                work_valid,
   input  ordfd_pkg::work_type work,
   output logic                work_ready,
   input  ordfd_pkg::cfg_type  cfg,
   ordfd_rsp_if.source         rsp
);

   // floor(s * 255 / 93) == (s * SCALE_RECIP) >> 22 for s <= 95
   localparam logic [23:0] SCALE_RECIP = 24'd11500755;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_index_ff;
   logic       is_white_ff;
   logic       eol_ff;

   logic        take;
   logic [30:0] scale_prod;
   logic [7:0]  scaled, intensity;
   logic        white;

   assign work_ready = !rsp_valid_ff || rsp.ready;
   assign take       = work_valid && work_ready;

   // intensity and threshold compare
   assign scale_prod = 31'(work.level_sum) * 31'(SCALE_RECIP);
   assign scaled     = (scale_prod[30:22] > 9'd255) ? 8'd255 : scale_prod[29:22];
   assign intensity  = work.from_palette ? work.pal_level : scaled;
   assign white      = (intensity != 8'd0) && (intensity >= work.threshold);

   always_comb begin
      if (take)           rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   // response payload
   always_ff @(posedge clock) begin
      if (take) begin
         out_index_ff <= white ? cfg.white_index : cfg.black_index;
         is_white_ff  <= white;
         eol_ff       <= work.line_end;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_index   = out_index_ff;
   assign rsp.is_white    = is_white_ff;
   assign rsp.end_of_line = eol_ff;

endmodule

[design/ordfd_checker.sv]
// port level checks for the ordered dither block, bound to the top level
// depends on ordered_dither_to_monochrome_top_assert.svh
`include "ordered_dither_to_monochrome_top_assert.svh"

module ordfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_index,
   input logic       rsp_is_white,
   input logic       rsp_end_of_line
);

   // no response beat right after reset
   `ORDFD_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // a stalled response beat stays offered
   `ORDFD_ASSERT(a_rsp_hold_valid, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp valid dropped")

   // and keeps its payload
   `ORDFD_ASSERT(a_rsp_hold_data, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_out_index) && $stable(rsp_is_white) && $stable(rsp_end_of_line), "rsp payload changed")

   // back pressure on the request side only comes from a held response
   `ORDFD_ASSERT(a_req_stall_cause, clock, reset, !req_ready |-> rsp_valid, "req stalled with rsp idle")

endmodule

bind ordered_dither_to_monochrome_top ordfd_checker u_ordfd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_index   (rsp_bus.out_index),
   .rsp_is_white    (rsp_bus.is_white),
   .rsp_end_of_line (rsp_bus.end_of_line)
);

[tb/ordfd_dither_check.sv]
`timescale 1ns / 100ps
// watches the request, response and register ports of the ordered dither block,
// predicts each pixel's color and compares it; depends on ordfd_pkg and ordfd_if
module ordfd_dither_check (
   input  logic       clock,
   input  logic       reset,
   ordfd_req_if       req_mon,
   ordfd_rsp_if       rsp_mon,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wr_data,
   output int         fail_count,
   output int         pending_count
);

   typedef struct packed {
      logic [7:0] out_index;
      logic       is_white;
      logic       end_of_line;
   } mono_pixel_type;

   mono_pixel_type expected_pixels[$];
   mono_pixel_type want_pixel;
   mono_pixel_type next_pixel;
   logic [7:0]  intensity_table [256];
   logic [3:0]  col_phase;
   logic [3:0]  row_phase;
   logic [1:0]  cur_format;
   logic [7:0]  white_code;
   logic [7:0]  black_code;
   logic [7:0]  level;
   int          mismatches = 0;

   assign fail_count = mismatches;

   // one printed line per mismatch
   task automatic report_mismatch(string msg);
      $display("dither check: %s (at %0t)", msg, $time);
      mismatches++;
   endtask

   // 16x16 recursive bayer threshold: each bit pair of row/col is a 2x2 step,
   // the top level puts row-only before column-only
   function automatic logic [7:0] bayer_threshold(logic [3:0] row, logic [3:0] col);
      return {row[0] ^ col[0], row[0], row[1] ^ col[1], row[1],
              row[2] ^ col[2], row[2], row[3] ^ col[3], col[3]};
   endfunction

   // floor(s*255/93), saturated
   function automatic logic [7:0] scale_level(int unsigned s);
      int unsigned v;
      v = s * 255 / 93;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic int unsigned clip_level(logic [9:0] lvl);
      return (lvl > 10'd1000) ? 1000 : int'(lvl);
   endfunction

   // palette entry from levels in thousandths
   function automatic logic [7:0] palette_level(logic [9:0] r, logic [9:0] g, logic [9:0] b);
      int unsigned v;
      v = (clip_level(r) + clip_level(g) + clip_level(b)) * 256 / 3000;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic logic [7:0] pixel_intensity(logic [23:0] pix);
      int unsigned s;
      case (cur_format)
         ordfd_pkg::FMT_PALETTE: return intensity_table[pix[7:0]];
         ordfd_pkg::FMT_RGB16: begin
            s = int'(pix[4:0]) + int'(pix[10:6]) + int'(pix[15:11]);
            return scale_level(s);
         end
         // 24-bit rgb, the unused code included
         default: begin
            s = (int'(pix[23:16]) + int'(pix[15:8]) + int'(pix[7:0])) >> 3;
            return scale_level(s);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         col_phase  = 4'd0;
         row_phase  = 4'd0;
         cur_format = ordfd_pkg::FMT_PALETTE;
         white_code = 8'd0;
         black_code = 8'd255;
         expected_pixels.delete();
      end else begin
         // register writes
         if (csr_wr_en) begin
            case (csr_index)
               ordfd_pkg::CSR_PIXEL_FORMAT: cur_format = csr_wr_data[1:0];
               ordfd_pkg::CSR_WHITE_INDEX:  white_code = csr_wr_data;
               ordfd_pkg::CSR_BLACK_INDEX:  black_code = csr_wr_data;
               default: ;
            endcase
         end

         // response beat against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("response beat with nothing expected, index %0d",
                                         rsp_mon.out_index));
            end else begin
               want_pixel = expected_pixels.pop_front();
               if (rsp_mon.out_index !== want_pixel.out_index)
                  report_mismatch($sformatf("out_index got %0d expected %0d",
                                            rsp_mon.out_index, want_pixel.out_index));
               if (rsp_mon.is_white !== want_pixel.is_white)
                  report_mismatch($sformatf("is_white got %0b expected %0b",
                                            rsp_mon.is_white, want_pixel.is_white));
               if (rsp_mon.end_of_line !== want_pixel.end_of_line)
                  report_mismatch($sformatf("end_of_line got %0b expected %0b",
                                            rsp_mon.end_of_line, want_pixel.end_of_line));
            end
         end

         // request beat: palette load or pixel prediction
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.command == ordfd_pkg::CMD_LOAD) begin
               intensity_table[req_mon.entry_index] =
                  palette_level(req_mon.red_level, req_mon.green_level, req_mon.blue_level);
            end else begin
               if (req_mon.image_start) begin
                  col_phase = 4'd0;
                  row_phase = 4'd0;
               end
               level = pixel_intensity(req_mon.pixel_value);
               next_pixel.is_white = (level != 8'd0) &&
                                     (level >= bayer_threshold(row_phase, col_phase));
               next_pixel.out_index   = next_pixel.is_white ? white_code : black_code;
               next_pixel.end_of_line = req_mon.line_end;
               expected_pixels.push_back(next_pixel);
               if (req_mon.line_end) begin
                  col_phase = 4'd0;
                  row_phase = row_phase + 4'd1;
               end else begin
                  col_phase = col_phase + 4'd1;
               end
            end
         end
      end
      pending_count <= expected_pixels.size();
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// stimulus and verdict for the ordered dither to monochrome block
// depends on ordfd_pkg, ordfd_if, the block's top level and ordfd_dither_check
module testbench;

   // the unused format code, which the block treats as 24-bit rgb
   localparam logic [1:0] FMT_UNUSED = 2'd3;
   localparam int PHASES     = 8;
   localparam int PHASE_ITEMS = 220;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [1:0] csr_index;
   logic [7:0] csr_wr_data;
   int         fail_count;
   int         pending_count;
   bit         stalls_on;
   bit         entry_loaded [256];
   logic [7:0] loaded_entries[$];
   int         line_left;

   ordfd_req_if req_bus ();
   ordfd_rsp_if rsp_bus ();

   ordered_dither_to_monochrome_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   ordfd_dither_check dither_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // overall time limit
   initial begin
      #5000000;
      $display("testbench: done, errors");
      $finish;
   end

   // response side: ready with random stall bursts
   initial begin
      forever begin
         if (stalls_on && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   // one request beat, held until taken
   task automatic send_beat(logic cmd, logic [23:0] pix, logic [7:0] entry,
                            logic [9:0] r, logic [9:0] g, logic [9:0] b,
                            logic le, logic st);
      if (stalls_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.pixel_value <= pix;
      req_bus.entry_index <= entry;
      req_bus.red_level   <= r;
      req_bus.green_level <= g;
      req_bus.blue_level  <= b;
      req_bus.line_end    <= le;
      req_bus.image_start <= st;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (cmd == ordfd_pkg::CMD_LOAD && !entry_loaded[entry]) begin
         entry_loaded[entry] = 1'b1;
         loaded_entries.push_back(entry);
      end
   endtask

   task automatic load_entry(logic [7:0] entry, logic [9:0] r, logic [9:0] g, logic [9:0] b,
                             logic le, logic st);
      send_beat(ordfd_pkg::CMD_LOAD, 24'($urandom_range(0, 24'hFFFFFF)), entry, r, g, b,
                le, st);
   endtask

   task automatic send_pixel(logic [23:0] pix, logic le, logic st);
      send_beat(ordfd_pkg::CMD_PIXEL, pix, 8'($urandom_range(0, 255)),
                10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                10'($urandom_range(0, 1023)), le, st);
   endtask

   // let every expected pixel drain, then the block's latency for a trailing load
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // all three registers, back to back while idle
   task automatic set_config(logic [1:0] fmt, logic [7:0] white, logic [7:0] black);
      csr_wr_en   <= 1'b1;
      csr_index   <= ordfd_pkg::CSR_PIXEL_FORMAT;
      csr_wr_data <= {6'd0, fmt};
      @(posedge clock);
      csr_index   <= ordfd_pkg::CSR_WHITE_INDEX;
      csr_wr_data <= white;
      @(posedge clock);
      csr_index   <= ordfd_pkg::CSR_BLACK_INDEX;
      csr_wr_data <= black;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [9:0] random_level();
      case ($urandom_range(0, 7))
         0: return 10'd0;
         1: return 10'd1023;
         2: return 10'($urandom_range(990, 1023));
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   // random beat: mostly pixels in lines and images, some palette loads
   task automatic send_random_beat(logic [1:0] fmt);
      logic [23:0] pix;
      logic        le;
      logic        st;
      if ($urandom_range(0, 5) == 0 ||
          (fmt == ordfd_pkg::FMT_PALETTE && loaded_entries.size() == 0)) begin
         load_entry(8'($urandom_range(0, 255)), random_level(), random_level(),
                    random_level(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
         pix = 24'($urandom_range(0, 24'hFFFFFF));
         case (fmt)
            ordfd_pkg::FMT_PALETTE:
               pix[7:0] = loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
            ordfd_pkg::FMT_RGB16: begin
               case ($urandom_range(0, 7))
                  0: pix[15:0] = 16'hFFFF;
                  1: pix[15:0] = pix[15:0] & 16'h0020;
                  default: ;
               endcase
            end
            default: begin
               case ($urandom_range(0, 7))
                  0: pix = 24'hFFFFFF;
                  1: pix = 24'h000000;
                  2: pix = pix & 24'h0F0F0F;
                  default: ;
               endcase
            end
         endcase
         // images start rarely; lines of 1 to 24 pixels, with stray line ends
         st = ($urandom_range(0, 299) == 0);
         if (st) line_left = $urandom_range(1, 24);
         le = (line_left <= 1) || ($urandom_range(0, 99) == 0);
         if (le) line_left = $urandom_range(1, 24);
         else    line_left--;
         send_pixel(pix, le, st);
      end
   endtask

   initial begin
      logic [1:0] fmt;
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_index           <= ordfd_pkg::CSR_PIXEL_FORMAT;
      csr_wr_data         <= 8'd0;
      req_bus.valid       <= 1'b0;
      req_bus.command     <= ordfd_pkg::CMD_LOAD;
      req_bus.pixel_value <= 24'd0;
      req_bus.entry_index <= 8'd0;
      req_bus.red_level   <= 10'd0;
      req_bus.green_level <= 10'd0;
      req_bus.blue_level  <= 10'd0;
      req_bus.line_end    <= 1'b0;
      req_bus.image_start <= 1'b0;
      stalls_on = 1'b1;
      line_left = 8;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // palette format: level extremes, marks on loads, unused upper pixel bits
      set_config(ordfd_pkg::FMT_PALETTE, 8'hFF, 8'h00);
      load_entry(8'd0, 10'd0, 10'd0, 10'd0, 1'b1, 1'b1);
      load_entry(8'd255, 10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b0);
      load_entry(8'd1, 10'd1000, 10'd1000, 10'd999, 1'b0, 1'b0);
      load_entry(8'd2, 10'd0, 10'd0, 10'd12, 1'b0, 1'b0);
      send_pixel(24'h000000, 1'b0, 1'b1);
      send_pixel(24'hFFFF02, 1'b0, 1'b0);
      send_pixel(24'h0000FF, 1'b1, 1'b0);
      send_pixel(24'h000001, 1'b0, 1'b0);
      wait_drained();

      // packed 16-bit: zero, only the unused bit, all fields full, smallest sum
      set_config(ordfd_pkg::FMT_RGB16, 8'h00, 8'hFF);
      send_pixel(24'h000000, 1'b0, 1'b1);
      send_pixel(24'hFF0020, 1'b0, 1'b0);
      send_pixel(24'h00FFDF, 1'b0, 1'b0);
      send_pixel(24'h000001, 1'b1, 1'b0);
      wait_drained();

      // 24-bit rgb: saturated sum, zero, small sums
      set_config(ordfd_pkg::FMT_RGB24, 8'h5A, 8'hA5);
      send_pixel(24'hFFFFFF, 1'b0, 1'b1);
      send_pixel(24'h000000, 1'b0, 1'b0);
      send_pixel(24'h070707, 1'b0, 1'b0);
      send_pixel(24'h0000FF, 1'b1, 1'b0);
      wait_drained();

      // unused format code, white and black alike
      set_config(FMT_UNUSED, 8'h00, 8'h00);
      send_pixel(24'hFFFFFF, 1'b0, 1'b1);
      send_pixel(24'h102030, 1'b1, 1'b0);
      wait_drained();

      // random phases: every format first, then random settings; no stalls at the end
      for (int phase = 0; phase < PHASES; phase++) begin
         fmt = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
         stalls_on = (phase != 2) && (phase < PHASES - 2);
         set_config(fmt, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         for (int n = 0; n < PHASE_ITEMS; n++) send_random_beat(fmt);
         wait_drained();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
